FILE: hw/rtl/rx256_pkg.sv
// Shared types and constants for the RGB to xterm-256 palette mapper.
`timescale 1ns / 1ps

package rx256_pkg;

  typedef logic [7:0] comp_t;   // one colour component
  typedef logic [2:0] level_t;  // cube level 0..5
  typedef logic [7:0] pidx_t;   // palette index

  // Upper edge of each cube level's catchment; halfway ties go low.
  localparam comp_t LVL0_TOP = 8'd47;   // between 0x00 and 0x5f
  localparam comp_t LVL1_TOP = 8'd115;  // between 0x5f and 0x87
  localparam comp_t LVL2_TOP = 8'd155;  // between 0x87 and 0xaf
  localparam comp_t LVL3_TOP = 8'd195;  // between 0xaf and 0xd7
  localparam comp_t LVL4_TOP = 8'd235;  // between 0xd7 and 0xff

  localparam pidx_t CUBE_BASE  = 8'd16;
  localparam pidx_t GREY_BASE  = 8'd232;
  localparam pidx_t CUBE_WHITE = 8'd231;
  localparam comp_t GREY_OFS   = 8'h08;
  localparam int    GREY_STEPS = 24;

  // Divide by ten as multiply by 205 and shift by 11, exact below 1029.
  localparam logic [7:0] DIV10_MUL = 8'd205;
  localparam int         DIV10_SHR = 11;

endpackage

FILE: hw/rtl/rx256_map.sv
// Combinational colour to palette index mapping: grey ramp or 6x6x6 cube.
`timescale 1ns / 1ps

module rx256_map
  import rx256_pkg::*;
(
  input  comp_t red_i,
  input  comp_t green_i,
  input  comp_t blue_i,
  output pidx_t palette_index_o
);

  function automatic level_t snap_level(input comp_t c);
    level_t lv;
    if (c <= LVL0_TOP)      lv = 3'd0;
    else if (c <= LVL1_TOP) lv = 3'd1;
    else if (c <= LVL2_TOP) lv = 3'd2;
    else if (c <= LVL3_TOP) lv = 3'd3;
    else if (c <= LVL4_TOP) lv = 3'd4;
    else                    lv = 3'd5;
    return lv;
  endfunction

  level_t      lvl_r, lvl_g, lvl_b;
  pidx_t       cube_idx;
  comp_t       grey_ofs;
  logic [15:0] grey_prod;
  logic [4:0]  grey_step;
  pidx_t       grey_idx;
  logic        is_grey;

  assign lvl_r = snap_level(red_i);
  assign lvl_g = snap_level(green_i);
  assign lvl_b = snap_level(blue_i);

  // 36*r + 6*g + b fits in 8 bits for levels up to 5
  assign cube_idx = CUBE_BASE
                  + 8'(({5'd0, lvl_r} << 5) + ({5'd0, lvl_r} << 2))
                  + 8'(({5'd0, lvl_g} << 2) + ({5'd0, lvl_g} << 1))
                  + {5'd0, lvl_b};

  // Values below the grey offset clamp to the first ramp step.
  assign grey_ofs  = (red_i >= GREY_OFS) ? (red_i - GREY_OFS) : '0;
  assign grey_prod = 16'(grey_ofs) * 16'(DIV10_MUL);
  assign grey_step = grey_prod[DIV10_SHR +: 5];

  // The last step wraps onto the cube's white entry.
  assign grey_idx = (grey_step >= 5'(GREY_STEPS)) ? CUBE_WHITE
                                                 : GREY_BASE + {3'd0, grey_step};

  assign is_grey = (red_i == green_i) && (green_i == blue_i);

  assign palette_index_o = is_grey ? grey_idx : cube_idx;

endmodule

FILE: hw/rtl/rgb_to_xterm256_index.sv
// Top level of the RGB to xterm-256 palette index mapper.
`timescale 1ns / 1ps
//
// Takes one 24-bit colour per word on the input channel (red_i, green_i,
// blue_i under in_valid_i / in_ready_o) and returns one palette index per
// word on the output channel (palette_index_o under out_valid_o /
// out_ready_i). Grey colours map onto the 24-step grey ramp or onto the
// cube's white entry, all others onto the 6x6x6 colour cube.
// A word accepted passes the input register, then the mapping logic into
// the result register, which drives the output channel. Throughput: one
// word per cycle while the receiver keeps taking words, set by the input
// register and the result register with the mapping logic between them.
// Reset empties both registers; no word appears until one is accepted.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more word; after that in_ready_o drops
// until the output side moves again. No state is kept between words.
//
module rgb_to_xterm256_index
  import rx256_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  comp_t red_i,
  input  comp_t green_i,
  input  comp_t blue_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output pidx_t palette_index_o
);

  logic  in_vld_q, in_vld_d;
  comp_t red_q, green_q, blue_q;
  logic  out_vld_q, out_vld_d;
  pidx_t pidx_q;
  pidx_t map_idx;
  logic  out_free;
  logic  in_load;

  // Result register frees up when empty or being drained.
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || out_free;
  assign in_load    = in_valid_i && in_ready_o;

  assign in_vld_d  = in_load || (in_vld_q && !out_free);
  assign out_vld_d = out_free ? in_vld_q : out_vld_q;

  rx256_map u_map (
    .red_i          (red_q),
    .green_i        (green_q),
    .blue_i         (blue_q),
    .palette_index_o(map_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    if (out_free && in_vld_q) begin
      pidx_q <= map_idx;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign palette_index_o = pidx_q;

endmodule

FILE: hw/rtl/rx256_chk.sv
// Port-level checker for the palette mapper, bound to the top level.
`timescale 1ns / 1ps

module rx256_chk
  import rx256_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input comp_t red_i,
  input comp_t green_i,
  input comp_t blue_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input pidx_t palette_index_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(palette_index_o))
    else $error("stalled result word changed or dropped");

  // Indexes below the cube never appear.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> palette_index_o >= CUBE_BASE)
    else $error("palette index below cube base");

  // A word accepted reaches the output via the input and result registers if the output drains.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("accepted word did not reach the output in time");

  // Grey input lands on the grey ramp or cube white.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && red_i == green_i && green_i == blue_i)
      ##1 out_ready_i |=> palette_index_o >= CUBE_WHITE)
    else $error("grey input mapped outside the grey ramp");

endmodule

bind rgb_to_xterm256_index rx256_chk u_rx256_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .red_i          (red_i),
  .green_i        (green_i),
  .blue_i         (blue_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .palette_index_o(palette_index_o)
);
